@@ hw/rtl/pbht_pkg.sv @@
// pbht_pkg: operation and status codes, register map and fixed field widths
// for the packet buffer handle table. No dependencies.
`default_nettype none

package pbht_pkg;

  localparam int ID_W   = 32;
  localparam int TIME_W = 32;
  localparam int HOLD_W = 8;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [0:0]        REG_HOLD_TIME = 1'b0;
  localparam logic [HOLD_W-1:0] HOLD_RESET    = 8'd1;

  localparam logic [1:0] OP_SAVE     = 2'd0;
  localparam logic [1:0] OP_RETRIEVE = 2'd1;
  localparam logic [1:0] OP_DISCARD  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

endpackage

`default_nettype wire

@@ hw/rtl/packet_buffer_handle_table.sv @@
// packet_buffer_handle_table: top level; APB register, ring position,
// input stage and result register. Depends on pbht_pkg, pbht_slot_mem, pbht_exec.
//
// Usage:
//   Request channel (op_valid/op_stall): operation, lookup_id, handle, now.
//   Result channel (result_valid/result_stall): status, new_id, out_handle,
//   out_valid, released_handle, released_valid; one result beat per request.
//   APB port: hold_time at address 0, written while the block is idle.
//   Path: an accepted request is registered in the input stage, then its result in the result register.
//   Throughput: one request per cycle while op_stall is low; the slot
//   read-modify-write has its read registered at accept and forwarding
//   from the write of the beat ahead.
//   Reset: a clearing sweep writes all 2^INDEX_BITS slots, one per cycle;
//   op_stall stays high until the sweep has finished.
//   Receiver stall: the result register holds; the stage ahead holds its
//   beat too, and op_stall rises only once both are full.
`default_nettype none

module packet_buffer_handle_table import pbht_pkg::*; #(
  parameter int INDEX_BITS  = 8,
  parameter int COOKIE_BITS = 24,
  parameter int HANDLE_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [APB_ADDR_W-1:0]  paddr,
  input  wire logic [APB_DATA_W-1:0]  pwdata,
  output      logic [APB_DATA_W-1:0]  prdata,
  output      logic                   pready,
  input  wire logic                   op_valid,
  output      logic                   op_stall,
  input  wire logic [1:0]             operation,
  input  wire logic [ID_W-1:0]        lookup_id,
  input  wire logic [HANDLE_BITS-1:0] handle,
  input  wire logic [TIME_W-1:0]      now,
  output      logic                   result_valid,
  input  wire logic                   result_stall,
  output      logic [1:0]             status,
  output      logic [ID_W-1:0]        new_id,
  output      logic [HANDLE_BITS-1:0] out_handle,
  output      logic                   out_valid,
  output      logic [HANDLE_BITS-1:0] released_handle,
  output      logic                   released_valid
);

  localparam int ENTRY_W = 1 + COOKIE_BITS + TIME_W + HANDLE_BITS;

  logic [HOLD_W-1:0]      hold_time;
  logic                   cfg_wr;
  logic [INDEX_BITS-1:0]  ring_position;
  logic [INDEX_BITS-1:0]  ring_next;
  logic [INDEX_BITS-1:0]  rd_addr;
  logic                   accept;
  logic                   clr_busy;

  logic                   s1_valid;
  logic                   s1_adv;
  logic [1:0]             s1_op;
  logic [ID_W-1:0]        s1_id;
  logic [HANDLE_BITS-1:0] s1_handle;
  logic [TIME_W-1:0]      s1_now;
  logic [INDEX_BITS-1:0]  s1_idx;

  logic [ENTRY_W-1:0]     entry;
  logic [ENTRY_W-1:0]     entry_next;
  logic                   ex_we;
  logic                   mem_wr;
  logic [1:0]             ex_status;
  logic [ID_W-1:0]        ex_new_id;
  logic [HANDLE_BITS-1:0] ex_out_handle;
  logic                   ex_out_valid;
  logic [HANDLE_BITS-1:0] ex_rel_handle;
  logic                   ex_rel_valid;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_HOLD_TIME);
  assign prdata = (paddr[2] == REG_HOLD_TIME) ? APB_DATA_W'(hold_time) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_time <= HOLD_RESET;
    end else if (cfg_wr) begin
      hold_time <= pwdata[HOLD_W-1:0];
    end
  end

  // request side
  assign s1_adv    = s1_valid && (!result_valid || !result_stall);
  assign op_stall  = clr_busy || (s1_valid && !s1_adv);
  assign accept    = op_valid && !op_stall;
  assign ring_next = ring_position + 1'b1;
  assign rd_addr   = (operation == OP_SAVE) ? ring_next : lookup_id[INDEX_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_position <= '0;
    end else if (accept && (operation == OP_SAVE)) begin
      ring_position <= ring_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op     <= operation;
      s1_id     <= lookup_id;
      s1_handle <= handle;
      s1_now    <= now;
      s1_idx    <= rd_addr;
    end
  end

  assign mem_wr = s1_adv && ex_we;

  pbht_slot_mem #(
    .INDEX_BITS (INDEX_BITS),
    .ENTRY_W    (ENTRY_W)
  ) u_slot_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (entry),
    .wr_en   (mem_wr),
    .wr_addr (s1_idx),
    .wr_data (entry_next),
    .busy    (clr_busy)
  );

  pbht_exec #(
    .INDEX_BITS  (INDEX_BITS),
    .COOKIE_BITS (COOKIE_BITS),
    .HANDLE_BITS (HANDLE_BITS),
    .ENTRY_W     (ENTRY_W)
  ) u_exec (
    .operation       (s1_op),
    .lookup_id       (s1_id),
    .handle          (s1_handle),
    .now             (s1_now),
    .hold_time       (hold_time),
    .idx             (s1_idx),
    .entry           (entry),
    .entry_next      (entry_next),
    .wr_en           (ex_we),
    .status          (ex_status),
    .new_id          (ex_new_id),
    .out_handle      (ex_out_handle),
    .out_valid       (ex_out_valid),
    .released_handle (ex_rel_handle),
    .released_valid  (ex_rel_valid)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      status          <= ex_status;
      new_id          <= ex_new_id;
      out_handle      <= ex_out_handle;
      out_valid       <= ex_out_valid;
      released_handle <= ex_rel_handle;
      released_valid  <= ex_rel_valid;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/pbht_slot_mem.sv @@
// pbht_slot_mem: slot store with registered read, write-to-read forwarding
// and a clearing sweep after reset. No dependencies.
`default_nettype none

module pbht_slot_mem #(
  parameter int INDEX_BITS = 8,
  parameter int ENTRY_W    = 73
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  rd_en,
  input  wire logic [INDEX_BITS-1:0] rd_addr,
  output      logic [ENTRY_W-1:0]    rd_data,
  input  wire logic                  wr_en,
  input  wire logic [INDEX_BITS-1:0] wr_addr,
  input  wire logic [ENTRY_W-1:0]    wr_data,
  output      logic                  busy
);

  localparam int DEPTH = 2 ** INDEX_BITS;

  logic [ENTRY_W-1:0]    mem [DEPTH];
  logic [ENTRY_W-1:0]    rd_q;
  logic [ENTRY_W-1:0]    byp_data;
  logic                  byp;
  logic                  clr_busy;
  logic [INDEX_BITS-1:0] clr_addr;
  logic                  mem_we;
  logic [INDEX_BITS-1:0] mem_wa;
  logic [ENTRY_W-1:0]    mem_wd;

  assign mem_we = clr_busy | wr_en;
  assign mem_wa = clr_busy ? clr_addr : wr_addr;
  assign mem_wd = clr_busy ? '0 : wr_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_q     <= mem[rd_addr];
      byp_data <= wr_data;
    end
  end

  // same-slot write in the read cycle: take the new entry
  always_ff @(posedge clk) begin
    if (rst) begin
      byp <= 1'b0;
    end else if (rd_en) begin
      byp <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1) begin
        clr_busy <= 1'b0;
      end
    end
  end

  assign rd_data = byp ? byp_data : rd_q;
  assign busy    = clr_busy;

endmodule

`default_nettype wire

@@ hw/rtl/pbht_exec.sv @@
// pbht_exec: per-beat slot update and result computation (combinational).
// Depends on pbht_pkg.
`default_nettype none

module pbht_exec import pbht_pkg::*; #(
  parameter int INDEX_BITS  = 8,
  parameter int COOKIE_BITS = 24,
  parameter int HANDLE_BITS = 16,
  parameter int ENTRY_W     = 1 + COOKIE_BITS + TIME_W + HANDLE_BITS
) (
  input  wire logic [1:0]             operation,
  input  wire logic [ID_W-1:0]        lookup_id,
  input  wire logic [HANDLE_BITS-1:0] handle,
  input  wire logic [TIME_W-1:0]      now,
  input  wire logic [HOLD_W-1:0]      hold_time,
  input  wire logic [INDEX_BITS-1:0]  idx,
  input  wire logic [ENTRY_W-1:0]     entry,
  output      logic [ENTRY_W-1:0]     entry_next,
  output      logic                   wr_en,
  output      logic [1:0]             status,
  output      logic [ID_W-1:0]        new_id,
  output      logic [HANDLE_BITS-1:0] out_handle,
  output      logic                   out_valid,
  output      logic [HANDLE_BITS-1:0] released_handle,
  output      logic                   released_valid
);

  typedef struct packed {
    logic                   occupied;
    logic [COOKIE_BITS-1:0] cookie;
    logic [TIME_W-1:0]      expiry;
    logic [HANDLE_BITS-1:0] handle;
  } entry_t;

  localparam int IDF_W = INDEX_BITS + COOKIE_BITS;
  localparam logic [COOKIE_BITS:0] COOKIE_LIMIT = {1'b0, {COOKIE_BITS{1'b1}}};

  entry_t                 cur;
  entry_t                 nxt;
  logic [TIME_W:0]        exp_sum;
  logic [TIME_W-1:0]      exp_sat;
  logic [COOKIE_BITS:0]   ck_inc;
  logic [COOKIE_BITS-1:0] ck_new;
  logic [IDF_W-1:0]       id_full;
  logic [ID_W-1:0]        id_cookie;

  assign cur       = entry_t'(entry);
  assign exp_sum   = {1'b0, now} + (TIME_W + 1)'(hold_time);
  assign exp_sat   = exp_sum[TIME_W] ? '1 : exp_sum[TIME_W-1:0];
  assign ck_inc    = {1'b0, cur.cookie} + 1'b1;
  assign ck_new    = (ck_inc >= COOKIE_LIMIT) ? '0 : ck_inc[COOKIE_BITS-1:0];
  assign id_full   = {ck_new, idx};
  assign id_cookie = lookup_id >> INDEX_BITS;

  always_comb begin
    nxt             = cur;
    wr_en           = 1'b0;
    status          = ST_OK;
    new_id          = '0;
    out_handle      = '0;
    out_valid       = 1'b0;
    released_handle = '0;
    released_valid  = 1'b0;
    unique case (operation)
      OP_SAVE: begin
        if (cur.occupied && (now < cur.expiry)) begin
          status = ST_MISMATCH;
          new_id = '1;
        end else begin
          if (cur.occupied) begin
            released_handle = cur.handle;
            released_valid  = 1'b1;
          end
          nxt.occupied = 1'b1;
          nxt.cookie   = ck_new;
          nxt.expiry   = exp_sat;
          nxt.handle   = handle;
          wr_en        = 1'b1;
          new_id       = ID_W'(id_full);
        end
      end
      OP_RETRIEVE, OP_DISCARD: begin
        if (id_cookie != ID_W'(cur.cookie)) begin
          status = ST_MISMATCH;
        end else if (!cur.occupied) begin
          status = ST_EMPTY;
        end else begin
          nxt.occupied = 1'b0;
          wr_en        = 1'b1;
          if (operation == OP_RETRIEVE) begin
            out_handle = cur.handle;
            out_valid  = 1'b1;
          end else begin
            released_handle = cur.handle;
            released_valid  = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign entry_next = nxt;

endmodule

`default_nettype wire

@@ hw/rtl/pbht_checker.sv @@
// pbht_checker: port-level assertions for packet_buffer_handle_table, bound
// to the top level. Depends on pbht_pkg.
`default_nettype none

module pbht_checker import pbht_pkg::*; (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            op_stall,
  input wire logic            result_valid,
  input wire logic            result_stall,
  input wire logic [1:0]      status,
  input wire logic [ID_W-1:0] new_id,
  input wire logic            out_valid,
  input wire logic            released_valid
);

  // clearing sweep blocks requests straight after reset
  a_stall_after_rst: assert property (@(posedge clk) rst |=> op_stall)
    else $error("requests accepted during clearing sweep");

  a_no_result_after_rst: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result beat straight after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(status) && $stable(new_id))
    else $error("stalled result beat changed");

  a_fail_no_handle: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status != ST_OK) |-> !out_valid && !released_valid)
    else $error("failed request carries a handle");

  a_one_handle: assert property (@(posedge clk) disable iff (rst)
    result_valid && out_valid |-> !released_valid)
    else $error("retrieve also releases a handle");

endmodule

bind packet_buffer_handle_table pbht_checker u_pbht_checker (
  .clk            (clk),
  .rst            (rst),
  .op_stall       (op_stall),
  .result_valid   (result_valid),
  .result_stall   (result_stall),
  .status         (status),
  .new_id         (new_id),
  .out_valid      (out_valid),
  .released_valid (released_valid)
);

`default_nettype wire

@@ verif/pbht_checker.sv @@
`timescale 1ns / 1ps
// pbht_scoreboard: tracks the handle table from the request, result and APB traffic
// it observes and compares every result beat with the oldest prediction.
// Depends on pbht_pkg.

module pbht_scoreboard import pbht_pkg::*; #(
  parameter int INDEX_BITS  = 8,
  parameter int COOKIE_BITS = 24,
  parameter int HANDLE_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [APB_ADDR_W-1:0]  paddr,
  input  wire logic [APB_DATA_W-1:0]  pwdata,
  input  wire logic                   pready,
  input  wire logic                   op_valid,
  input  wire logic                   op_stall,
  input  wire logic [1:0]             operation,
  input  wire logic [ID_W-1:0]        lookup_id,
  input  wire logic [HANDLE_BITS-1:0] handle,
  input  wire logic [TIME_W-1:0]      now,
  input  wire logic                   result_valid,
  input  wire logic                   result_stall,
  input  wire logic [1:0]             status,
  input  wire logic [ID_W-1:0]        new_id,
  input  wire logic [HANDLE_BITS-1:0] out_handle,
  input  wire logic                   out_valid,
  input  wire logic [HANDLE_BITS-1:0] released_handle,
  input  wire logic                   released_valid,
  output int                          mismatches,
  output int                          pending
);

  localparam int SLOTS = 1 << INDEX_BITS;
  localparam logic [APB_ADDR_W-1:0] HOLD_ADDR = APB_ADDR_W'({REG_HOLD_TIME, 2'b00});

  typedef struct packed {
    logic [1:0]             status;
    logic [ID_W-1:0]        new_id;
    logic [HANDLE_BITS-1:0] out_handle;
    logic                   out_valid;
    logic [HANDLE_BITS-1:0] released_handle;
    logic                   released_valid;
  } table_result_t;

  table_result_t          expected_results[$];
  logic [HOLD_W-1:0]      hold_time;
  logic [INDEX_BITS-1:0]  ring_pos;
  logic                   occupied [SLOTS];
  logic [COOKIE_BITS-1:0] cookie   [SLOTS];
  logic [TIME_W-1:0]      expiry   [SLOTS];
  logic [HANDLE_BITS-1:0] held     [SLOTS];
  int                     errors = 0;

  function automatic table_result_t apply_request(input logic [1:0]             op,
                                                  input logic [ID_W-1:0]        id,
                                                  input logic [HANDLE_BITS-1:0] hnd,
                                                  input logic [TIME_W-1:0]      t);
    table_result_t         r;
    logic [INDEX_BITS-1:0] idx;
    logic [TIME_W:0]       sum;
    logic [63:0]           bumped;
    r = '0;
    case (op)
      OP_SAVE: begin
        idx      = ring_pos + 1'b1;
        ring_pos = idx;
        if (occupied[idx] && t < expiry[idx]) begin
          r.status = ST_MISMATCH;
          r.new_id = '1;
        end else begin
          if (occupied[idx]) begin
            r.released_handle = held[idx];
            r.released_valid  = 1'b1;
          end
          bumped = 64'(cookie[idx]) + 64'd1;
          if (bumped >= (64'd1 << COOKIE_BITS) - 64'd1) bumped = '0;
          cookie[idx]   = COOKIE_BITS'(bumped);
          occupied[idx] = 1'b1;
          held[idx]     = hnd;
          sum           = {1'b0, t} + (TIME_W + 1)'(hold_time);
          expiry[idx]   = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
          r.status      = ST_OK;
          r.new_id      = ID_W'((bumped << INDEX_BITS) | 64'(idx));
        end
      end
      OP_RETRIEVE, OP_DISCARD: begin
        idx = id[INDEX_BITS-1:0];
        if ((id >> INDEX_BITS) != ID_W'(cookie[idx])) begin
          r.status = ST_MISMATCH;
        end else if (!occupied[idx]) begin
          r.status = ST_EMPTY;
        end else begin
          occupied[idx] = 1'b0;
          if (op == OP_RETRIEVE) begin
            r.out_handle = held[idx];
            r.out_valid  = 1'b1;
          end else begin
            r.released_handle = held[idx];
            r.released_valid  = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    table_result_t seen;
    table_result_t want;
    if (rst) begin
      hold_time = HOLD_RESET;
      ring_pos  = '0;
      for (int i = 0; i < SLOTS; i++) begin
        occupied[i] = 1'b0;
        cookie[i]   = '0;
        expiry[i]   = '0;
      end
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == HOLD_ADDR) begin
        hold_time = pwdata[HOLD_W-1:0];
      end
      if (result_valid && !result_stall) begin
        seen = {status, new_id, out_handle, out_valid, released_handle, released_valid};
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: result beat with none outstanding: st=%0d id=%h oh=%h/%b rh=%h/%b",
                     $time, seen.status, seen.new_id, seen.out_handle, seen.out_valid,
                     seen.released_handle, seen.released_valid);
          end
        end else begin
          want = expected_results.pop_front();
          if (seen !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: mismatch exp st=%0d id=%h oh=%h/%b rh=%h/%b", $time,
                       want.status, want.new_id, want.out_handle, want.out_valid,
                       want.released_handle, want.released_valid);
              $display("%0t:          got st=%0d id=%h oh=%h/%b rh=%h/%b", $time,
                       seen.status, seen.new_id, seen.out_handle, seen.out_valid,
                       seen.released_handle, seen.released_valid);
            end
          end
        end
      end
      if (op_valid && !op_stall) begin
        expected_results.push_back(apply_request(operation, lookup_id, handle, now));
      end
    end
    pending    <= expected_results.size();
    mismatches <= errors;
  end

endmodule

@@ verif/tb_packet_buffer_handle_table.sv @@
`timescale 1ns / 1ps
// tb_packet_buffer_handle_table: clock, reset, hold_time set-up and request
// stimulus for packet_buffer_handle_table; checking sits in pbht_scoreboard.
// Depends on pbht_pkg, pbht_scoreboard and the RTL.

module tb_packet_buffer_handle_table;
  import pbht_pkg::*;

  localparam int INDEX_BITS  = 8;
  localparam int COOKIE_BITS = 24;
  localparam int HANDLE_BITS = 16;
  localparam int PHASE_ITEMS = 250;
  localparam int PHASES      = 8;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [APB_ADDR_W-1:0] HOLD_ADDR = APB_ADDR_W'({REG_HOLD_TIME, 2'b00});

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   psel         = 1'b0;
  logic                   penable      = 1'b0;
  logic                   pwrite       = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr        = '0;
  logic [APB_DATA_W-1:0]  pwdata       = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;
  logic                   op_valid     = 1'b0;
  logic                   op_stall;
  logic [1:0]             operation    = OP_SAVE;
  logic [ID_W-1:0]        lookup_id    = '0;
  logic [HANDLE_BITS-1:0] handle       = '0;
  logic [TIME_W-1:0]      now          = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  logic [1:0]             status;
  logic [ID_W-1:0]        new_id;
  logic [HANDLE_BITS-1:0] out_handle;
  logic                   out_valid;
  logic [HANDLE_BITS-1:0] released_handle;
  logic                   released_valid;

  int                     mismatches;
  int                     pending;
  int                     send_idle_pct = 0;
  int                     stall_pct     = 0;
  logic [ID_W-1:0]        live_ids[$];
  logic [TIME_W-1:0]      clock_s = '0;

  always #5 clk = ~clk;

  packet_buffer_handle_table #(
    .INDEX_BITS  (INDEX_BITS),
    .COOKIE_BITS (COOKIE_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) i_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .op_valid, .op_stall, .operation, .lookup_id, .handle, .now,
    .result_valid, .result_stall, .status, .new_id, .out_handle, .out_valid,
    .released_handle, .released_valid
  );

  pbht_scoreboard #(
    .INDEX_BITS  (INDEX_BITS),
    .COOKIE_BITS (COOKIE_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) i_checker (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .op_valid, .op_stall, .operation, .lookup_id, .handle, .now,
    .result_valid, .result_stall, .status, .new_id, .out_handle, .out_valid,
    .released_handle, .released_valid, .mismatches, .pending
  );

  always @(posedge clk) result_stall <= !rst && ($urandom_range(99) < stall_pct);

  // ids handed out by successful saves feed later retrieve and discard beats
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall && status == ST_OK && new_id != '0) begin
      live_ids.push_back(new_id);
      if (live_ids.size() > 64) live_ids.pop_front();
    end
  end

  task automatic send_request(input logic [1:0]             op,
                              input logic [ID_W-1:0]        id,
                              input logic [HANDLE_BITS-1:0] h,
                              input logic [TIME_W-1:0]      t);
    while ($urandom_range(99) < send_idle_pct) begin
      op_valid <= 1'b0;
      @(posedge clk);
    end
    op_valid  <= 1'b1;
    operation <= op;
    lookup_id <= id;
    handle    <= h;
    now       <= t;
    @(posedge clk);
    while (op_stall) @(posedge clk);
  endtask

  task automatic write_hold_time(input logic [HOLD_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= HOLD_ADDR;
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain();
    op_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_request();
    int                pick;
    int                k;
    logic [ID_W-1:0]   id;
    logic [1:0]        op;
    logic [TIME_W-1:0] t;
    if ($urandom_range(3) == 0) clock_s = clock_s + 1'b1;
    pick = $urandom_range(99);
    id   = $urandom;
    op   = OP_SAVE;
    if (pick >= 45 && pick < 85 && live_ids.size() != 0) begin
      k  = $urandom_range(live_ids.size() - 1);
      id = live_ids[k];
      if ($urandom_range(1) == 1) live_ids.delete(k);
      if (pick >= 80) id = id ^ (ID_W'(1) << $urandom_range(ID_W - 1));
      op = (pick < 70) ? OP_RETRIEVE : OP_DISCARD;
    end else if (pick >= 45 && pick < 95) begin
      op = pick[0] ? OP_RETRIEVE : OP_DISCARD;
      if (pick[1]) id[ID_W-1:INDEX_BITS] = '0;
    end else if (pick >= 95) begin
      op = OP_UNUSED;
    end
    t = clock_s;
    k = $urandom_range(9);
    if (k == 0) t = $urandom;
    else if (k == 1) t = clock_s - TIME_W'($urandom_range(300));
    send_request(op, id, HANDLE_BITS'($urandom), t);
  endtask

  initial begin : stimulus
    logic [HOLD_W-1:0] hold_value;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // untouched slots: cookie 0 matches but slot empty, other cookies mismatch
    send_request(OP_RETRIEVE, 32'h0000_0000, '0, '0);
    send_request(OP_DISCARD,  32'h0000_00FF, '0, '0);
    send_request(OP_RETRIEVE, '1, '1, '1);
    send_request(OP_UNUSED,   '1, '1, '1);
    send_request(OP_SAVE,     '0, '1, '0);
    send_request(OP_SAVE,     '1, '0, '1);
    send_request(OP_SAVE,     '0, 16'h5A5A, 32'h8000_0000);
    send_request(OP_RETRIEVE, 32'h0000_0101, '0, '0);
    send_request(OP_RETRIEVE, 32'h0000_0101, '0, '0);
    send_request(OP_DISCARD,  32'h0000_0102, '0, '0);
    send_request(OP_DISCARD,  32'h8000_0103, '0, '0);
    send_request(OP_RETRIEVE, 32'h0000_0203, '0, '0);
    send_request(OP_DISCARD,  32'h0000_0103, '0, '0);
    send_request(OP_UNUSED,   '0, '0, '0);
    drain();
    write_hold_time('1);
    send_request(OP_SAVE,     '0, 16'h1234, 32'hFFFF_FF80);
    send_request(OP_SAVE,     '0, 16'h8001, 32'hFFFF_FF00);
    send_request(OP_RETRIEVE, 32'h0000_0104, '0, '1);
    send_request(OP_DISCARD,  32'h0000_0105, '0, '0);
    drain();
    write_hold_time('0);
    send_request(OP_SAVE,     '0, 16'h00FF, '0);
    send_request(OP_DISCARD,  32'h0000_0106, '0, '0);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p % 3)
        0:       hold_value = '1;
        1:       hold_value = '0;
        default: hold_value = HOLD_W'($urandom);
      endcase
      write_hold_time(hold_value);
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 75;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 75;
        end
        default: begin
          send_idle_pct = 37;
          stall_pct     = 37;
        end
      endcase
      repeat (PHASE_ITEMS) random_request();
    end

    drain();
    if (mismatches == 0) begin
      $display("tb_packet_buffer_handle_table: PASS");
    end else begin
      $display("tb_packet_buffer_handle_table: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_packet_buffer_handle_table: FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/pbht_pkg.sv
hw/rtl/pbht_slot_mem.sv
hw/rtl/pbht_exec.sv
hw/rtl/packet_buffer_handle_table.sv
hw/rtl/pbht_checker.sv
verif/pbht_checker.sv
verif/tb_packet_buffer_handle_table.sv
